// ===== design/pso_pkg.sv =====
// Package for the particle swarm optimizer: payload structs, codes and state encoding.
package pso_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_SWEEP = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_POS_MIN = 3'd0;
	localparam logic [2:0] REG_POS_MAX = 3'd1;
	localparam logic [2:0] REG_VEL_LIMIT = 3'd2;
	localparam logic [2:0] REG_FIT_SLOPE = 3'd3;
	localparam logic [2:0] REG_FIT_OFFSET = 3'd4;
	localparam logic [2:0] REG_FIT_TARGET = 3'd5;
	localparam logic [2:0] REG_STOP_ERROR = 3'd6;
	localparam logic [2:0] REG_PART_COUNT = 3'd7;

	localparam int CFG_W = 36;
	localparam logic [35:0] FIT_MAX = 36'hF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] particle;
		logic signed [31:0] init_position;
		logic signed [31:0] init_velocity;
		logic [15:0] rand_one;
		logic [15:0] rand_two;
	} in_item_t;

	typedef struct packed {
		logic [35:0] particle_fitness;
		logic signed [31:0] best_position;
		logic [35:0] best_fitness;
		logic converged;
		logic [15:0] sweep_count;
	} out_item_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_PULL1,
		ST_PULL2,
		ST_VEL,
		ST_POS,
		ST_STEP,
		ST_FIT1,
		ST_FIT2,
		ST_WRITE,
		ST_SCAN,
		ST_SCAN_END,
		ST_OUT
	} state_t;

	// Request to the shared multiplier.
	typedef struct packed {
		logic signed [33:0] a;
		logic signed [16:0] b;
	} mul_req_t;

endpackage

// ===== design/pso_mul.sv =====
// Shared registered signed multiplier, 34 by 17 bits.
module pso_mul
	import pso_pkg::*;
(
	input  logic clk,
	input  mul_req_t req,
	output logic signed [50:0] prod_q
);

	// One product per cycle, registered.
	always_ff @(posedge clk) begin
		prod_q <= 51'(req.a) * 51'(req.b);
	end

endmodule

// ===== design/particle_swarm_optimizer.sv =====
// Top level of the particle swarm optimizer: sequencer, particle memory and status.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_item_t
// out     | output    | out_valid/out_stall| out_item_t
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A move makes two pulls and then the fitness slope, a load only the fitness slope:
// each step uses the one shared multiplier at most once. A sweep end makes one
// memory read per particle over the clamped particle_count. The result sits in an
// output register; in_stall is high from acceptance until that result is taken,
// and the next item can be accepted in the cycle after that.
// Reset clears status and control, not the memory.
module particle_swarm_optimizer
	import pso_pkg::*;
#(
	parameter int MAX_PARTICLES = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IW = (MAX_PARTICLES > 2) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	// Configuration registers.
	logic signed [31:0] pos_min_q, pos_max_q;
	logic [30:0] vel_limit_q;
	logic signed [15:0] fit_slope_q;
	logic signed [35:0] fit_offset_q, fit_target_q;
	logic [35:0] stop_error_q;
	logic [7:0] part_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q <= 32'sd1048576;
			pos_max_q <= 32'sd1048576000;
			vel_limit_q <= 31'd10486;
			fit_slope_q <= 16'sd3328;
			fit_offset_q <= 36'sd17825792;
			fit_target_q <= 36'sd127926272;
			stop_error_q <= 36'd1049;
			part_count_q <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_MIN: pos_min_q <= cfg_data[31:0];
				REG_POS_MAX: pos_max_q <= cfg_data[31:0];
				REG_VEL_LIMIT: vel_limit_q <= cfg_data[30:0];
				REG_FIT_SLOPE: fit_slope_q <= cfg_data[15:0];
				REG_FIT_OFFSET: fit_offset_q <= cfg_data;
				REG_FIT_TARGET: fit_target_q <= cfg_data;
				REG_STOP_ERROR: stop_error_q <= cfg_data;
				REG_PART_COUNT: part_count_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Particle memory: position, velocity, own best position, own best fitness.
	localparam int ENT_W = 32 + 32 + 32 + 36;
	logic [ENT_W-1:0] mem [MAX_PARTICLES];
	logic [ENT_W-1:0] rd_data_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	logic signed [31:0] rd_pos, rd_vel, rd_bpos;
	logic [35:0] rd_bfit;
	assign {rd_pos, rd_vel, rd_bpos, rd_bfit} = rd_data_q;

	// Sequencer registers.
	state_t state_q, state_d;
	in_item_t item_q;
	logic signed [31:0] x_q, v_q, bpos_q;
	logic [35:0] bfit_q;
	logic signed [35:0] acc_q;
	logic [35:0] pfit_q;
	logic [CW-1:0] cnt_q;
	logic [35:0] scan_fit_q;
	logic signed [31:0] scan_pos_q;
	logic signed [31:0] gpos_q;
	logic [35:0] gfit_q;
	logic [15:0] sweep_q;
	logic out_valid_q;
	out_item_t out_q;

	mul_req_t mreq;
	logic signed [50:0] prod_q;

	pso_mul u_mul (
		.clk(clk),
		.req(mreq),
		.prod_q(prod_q)
	);

	logic idx_ok;
	assign idx_ok = (32'(item_q.particle) < 32'(MAX_PARTICLES));

	// Scan length, clamped to 1..MAX_PARTICLES.
	logic [CW-1:0] scan_n;
	always_comb begin
		if (part_count_q == 8'd0) begin
			scan_n = CW'(1);
		end else if (32'(part_count_q) > 32'(MAX_PARTICLES)) begin
			scan_n = CW'(MAX_PARTICLES);
		end else begin
			scan_n = CW'(part_count_q);
		end
	end

	// Velocity and position clamping on the accumulated sum.
	logic signed [35:0] vlim, vclamp;
	logic signed [35:0] xsum, xclamp;
	always_comb begin
		vlim = 36'(vel_limit_q);
		if (acc_q > vlim) begin
			vclamp = vlim;
		end else if (acc_q < -vlim) begin
			vclamp = -vlim;
		end else begin
			vclamp = acc_q;
		end
		xsum = 36'(x_q) + 36'(v_q);
		if (xsum > 36'(pos_max_q)) begin
			xclamp = 36'(pos_max_q);
		end else if (xsum < 36'(pos_min_q)) begin
			xclamp = 36'(pos_min_q);
		end else begin
			xclamp = xsum;
		end
	end

	// Fitness from the slope product.
	logic signed [51:0] model, diff;
	logic [51:0] mag;
	logic [35:0] fit_now;
	always_comb begin
		model = 52'(prod_q >>> 8) + 52'(fit_offset_q);
		diff = 52'(fit_target_q) - model;
		mag = diff[51] ? 52'(-diff) : 52'(diff);
		fit_now = (mag > 52'(FIT_MAX)) ? FIT_MAX : mag[35:0];
	end

	// Next state, memory and multiplier control.
	always_comb begin
		state_d = state_q;
		rd_addr = IW'(item_q.particle);
		wr_addr = IW'(item_q.particle);
		wr_en = 1'b0;
		wr_data = {x_q, v_q, bpos_q, bfit_q};
		mreq.a = 34'(x_q);
		mreq.b = 17'(fit_slope_q);
		case (state_q)
			ST_IDLE: begin
				// Read the offered particle so its entry is ready after acceptance.
				rd_addr = IW'(in_data.particle);
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (item_q.kind == KIND_LOAD && idx_ok) begin
					state_d = ST_FIT1;
				end else if (item_q.kind == KIND_MOVE && idx_ok) begin
					state_d = ST_PULL1;
				end else if (item_q.kind == KIND_SWEEP) begin
					rd_addr = '0;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_PULL1: begin
				mreq.a = 34'(rd_bpos) - 34'(rd_pos);
				mreq.b = 17'({1'b0, item_q.rand_one});
				state_d = ST_PULL2;
			end
			ST_PULL2: begin
				mreq.a = 34'(gpos_q) - 34'(x_q);
				mreq.b = 17'({1'b0, item_q.rand_two});
				state_d = ST_VEL;
			end
			ST_VEL: state_d = ST_POS;
			ST_POS: state_d = ST_STEP;
			ST_STEP: state_d = ST_FIT1;
			ST_FIT1: state_d = ST_FIT2;
			ST_FIT2: state_d = ST_WRITE;
			ST_WRITE: begin
				wr_en = 1'b1;
				state_d = ST_OUT;
			end
			ST_SCAN: begin
				rd_addr = IW'(cnt_q + CW'(1));
				if (cnt_q + CW'(1) >= scan_n) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_OUT;
			ST_OUT: begin
				if (out_valid_q && !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= in_data;
				pfit_q <= '0;
				cnt_q <= '0;
			end
			ST_READ: begin
				x_q <= (item_q.kind == KIND_LOAD) ? item_q.init_position : rd_pos;
				v_q <= (item_q.kind == KIND_LOAD) ? item_q.init_velocity : rd_vel;
				bpos_q <= rd_bpos;
				bfit_q <= rd_bfit;
			end
			ST_PULL2: acc_q <= 36'(v_q) + 36'(prod_q >>> 15);
			ST_VEL: acc_q <= acc_q + 36'(prod_q >>> 15);
			ST_POS: v_q <= vclamp[31:0];
			ST_STEP: x_q <= xclamp[31:0];
			ST_FIT2: begin
				pfit_q <= fit_now;
				if (item_q.kind == KIND_LOAD || fit_now < bfit_q) begin
					bfit_q <= fit_now;
					bpos_q <= x_q;
				end
			end
			ST_SCAN: begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == '0 || rd_bfit < scan_fit_q) begin
					scan_fit_q <= rd_bfit;
					scan_pos_q <= rd_bpos;
				end
			end
			default: ;
		endcase
	end

	// Global best and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpos_q <= '0;
			gfit_q <= FIT_MAX;
			sweep_q <= '0;
		end else if (state_q == ST_SCAN_END) begin
			gpos_q <= scan_pos_q;
			gfit_q <= scan_fit_q;
			if (sweep_q != 16'hFFFF) begin
				sweep_q <= sweep_q + 16'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !out_valid_q) begin
			out_q.particle_fitness <= pfit_q;
			out_q.best_position <= gpos_q;
			out_q.best_fitness <= gfit_q;
			out_q.converged <= (gfit_q <= stop_error_q);
			out_q.sweep_count <= sweep_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Output stays valid only while the sequencer waits to hand it off.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result shown outside hand-off");
	// A sweep end always counts unless saturated.
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_END && sweep_q != 16'hFFFF) |=> sweep_q == $past(sweep_q) + 16'd1)
		else $error("sweep not counted");
	// Scan index stays within the memory.
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 32'(cnt_q) < 32'(MAX_PARTICLES)) else $error("scan overrun");
	// Items are only taken when idle.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_READ) else $error("accept lost");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the particle swarm optimizer: driver, predictor and monitor.
module tb;
	import pso_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int NPART = 128;
	localparam int SETTLE = 160;
	localparam int STUCK_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	particle_swarm_optimizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Items waiting to be sent and results waiting to arrive.
	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int failures = 0;
	int stuck_cycles = 0;

	// Predicted configuration.
	longint c_pos_min, c_pos_max, c_vel_limit, c_slope, c_offset, c_goal;
	longint c_stop, c_count;

	// Predicted swarm state.
	longint pos_mem[NPART];
	longint vel_mem[NPART];
	longint own_pos[NPART];
	longint own_fit[NPART];
	longint glob_pos;
	longint glob_fit;
	longint sweeps;

	// Fitness |target - ((slope*x >>> 8) + offset)|, saturated to 36 bits.
	function automatic longint fitness_at(longint x);
		longint m, d;
		m = ((c_slope * x) >>> 8) + c_offset;
		d = c_goal - m;
		if (d < 0) d = -d;
		if (d > longint'(FIT_MAX)) d = longint'(FIT_MAX);
		return d;
	endfunction

	// Apply one accepted item to the swarm state and return the status it reports.
	function automatic out_item_t swarm_step(in_item_t it);
		out_item_t r;
		longint x, v, f, n;
		int i, bi;
		f = 0;
		i = it.particle;
		if (it.kind == KIND_LOAD) begin
			x = it.init_position;
			pos_mem[i] = x;
			vel_mem[i] = it.init_velocity;
			own_pos[i] = x;
			f = fitness_at(x);
			own_fit[i] = f;
		end else if (it.kind == KIND_MOVE) begin
			x = pos_mem[i];
			v = vel_mem[i] + ((longint'(it.rand_one) * (own_pos[i] - x)) >>> 15)
				+ ((longint'(it.rand_two) * (glob_pos - x)) >>> 15);
			if (v > c_vel_limit) v = c_vel_limit;
			else if (v < -c_vel_limit) v = -c_vel_limit;
			x = x + v;
			if (x > c_pos_max) x = c_pos_max;
			else if (x < c_pos_min) x = c_pos_min;
			vel_mem[i] = v;
			pos_mem[i] = x;
			f = fitness_at(x);
			if (f < own_fit[i]) begin
				own_fit[i] = f;
				own_pos[i] = x;
			end
		end else if (it.kind == KIND_SWEEP) begin
			n = c_count;
			if (n < 1) n = 1;
			if (n > NPART) n = NPART;
			bi = 0;
			for (int k = 1; k < n; k++)
				if (own_fit[k] < own_fit[bi]) bi = k;
			glob_pos = own_pos[bi];
			glob_fit = own_fit[bi];
			if (sweeps < 65535) sweeps++;
		end
		r.particle_fitness = f[35:0];
		r.best_position = glob_pos[31:0];
		r.best_fitness = glob_fit[35:0];
		r.converged = (glob_fit <= c_stop);
		r.sweep_count = sweeps[15:0];
		return r;
	endfunction

	function automatic in_item_t make_item(logic [1:0] k, logic [6:0] p, logic [31:0] x,
			logic [31:0] v, logic [15:0] r1, logic [15:0] r2);
		in_item_t it;
		it.kind = k;
		it.particle = p;
		it.init_position = x;
		it.init_velocity = v;
		it.rand_one = r1;
		it.rand_two = r2;
		return it;
	endfunction

	// Half the values span the full range, half stay within about +-256.0.
	function automatic logic [31:0] rand_q();
		if ($urandom_range(1)) return $urandom;
		return $urandom_range(32'h2000_0000) - 32'h1000_0000;
	endfunction

	function automatic in_item_t rand_item();
		int pick;
		logic [1:0] k;
		pick = $urandom_range(99);
		if (pick < 25) k = KIND_LOAD;
		else if (pick < 85) k = KIND_MOVE;
		else if (pick < 97) k = KIND_SWEEP;
		else k = KIND_UNUSED;
		return make_item(k, 7'($urandom_range(NPART - 1)), rand_q(), rand_q(),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
	endfunction

	// Write one register at the next edge; the enable stays high for back-to-back writes.
	task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_POS_MIN: c_pos_min = longint'($signed(val[31:0]));
			REG_POS_MAX: c_pos_max = longint'($signed(val[31:0]));
			REG_VEL_LIMIT: c_vel_limit = longint'(val[30:0]);
			REG_FIT_SLOPE: c_slope = longint'($signed(val[15:0]));
			REG_FIT_OFFSET: c_offset = longint'($signed(val[35:0]));
			REG_FIT_TARGET: c_goal = longint'($signed(val[35:0]));
			REG_STOP_ERROR: c_stop = longint'(val[35:0]);
			REG_PART_COUNT: c_count = longint'(val[7:0]);
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] pmin, logic [31:0] pmax, logic [30:0] vlim,
			logic [15:0] slope, logic [35:0] offs, logic [35:0] tgt, logic [35:0] stop,
			logic [7:0] cnt);
		write_reg(REG_POS_MIN, {{4{pmin[31]}}, pmin});
		write_reg(REG_POS_MAX, {{4{pmax[31]}}, pmax});
		write_reg(REG_VEL_LIMIT, {5'd0, vlim});
		write_reg(REG_FIT_SLOPE, {{20{slope[15]}}, slope});
		write_reg(REG_FIT_OFFSET, offs);
		write_reg(REG_FIT_TARGET, tgt);
		write_reg(REG_STOP_ERROR, stop);
		write_reg(REG_PART_COUNT, {28'd0, cnt});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Block until every queued item is sent and answered, then let the block settle.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) pending_items.push_back(rand_item());
	endtask

	// Driver: offer a new item once the previous one has gone.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall.
	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor: predict on input acceptance, check on output acceptance.
	always @(posedge clk) begin
		out_item_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(swarm_step(in_data));
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding: %h", out_data);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.particle_fitness !== want.particle_fitness) begin
					$error("particle_fitness expected %h actual %h",
						want.particle_fitness, out_data.particle_fitness);
					failures++;
				end
				if (out_data.best_position !== want.best_position) begin
					$error("best_position expected %h actual %h",
						want.best_position, out_data.best_position);
					failures++;
				end
				if (out_data.best_fitness !== want.best_fitness) begin
					$error("best_fitness expected %h actual %h",
						want.best_fitness, out_data.best_fitness);
					failures++;
				end
				if (out_data.converged !== want.converged) begin
					$error("converged expected %b actual %b",
						want.converged, out_data.converged);
					failures++;
				end
				if (out_data.sweep_count !== want.sweep_count) begin
					$error("sweep_count expected %h actual %h",
						want.sweep_count, out_data.sweep_count);
					failures++;
				end
			end
		end
		// Watchdog on lack of progress.
		if (moved) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		c_pos_min = 1048576;
		c_pos_max = 1048576000;
		c_vel_limit = 10486;
		c_slope = 3328;
		c_offset = 17825792;
		c_goal = 127926272;
		c_stop = 1049;
		c_count = 100;
		for (int k = 0; k < NPART; k++) begin
			pos_mem[k] = 0;
			vel_mem[k] = 0;
			own_pos[k] = 0;
			own_fit[k] = 0;
		end
		glob_pos = 0;
		glob_fit = longint'(FIT_MAX);
		sweeps = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: the sender idles in a third of the cycles, the receiver in nearly half.
		send_idle_pct = 34;
		recv_stall_pct = 46;
		set_config(32'd1048576, 32'd1048576000, 31'd10486, 16'd3328, 36'd17825792,
			36'd127926272, 36'd1049, 8'd100);
		// Directed: extreme positions and velocities, full and zero pulls, unused kind.
		pending_items.push_back(make_item(KIND_LOAD, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_LOAD, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF,
			16'hFFFF, 16'hFFFF));
		pending_items.push_back(make_item(KIND_MOVE, 7'd0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF));
		pending_items.push_back(make_item(KIND_MOVE, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_UNUSED, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		// Every particle is written before any sweep reads it.
		for (int k = 0; k < NPART; k++)
			pending_items.push_back(make_item(KIND_LOAD, 7'(k), rand_q(), rand_q(),
				16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_SWEEP, 7'd0, 32'h0, 32'h0, 16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_MOVE, 7'd5, 32'h0, 32'h0, 16'h8000, 16'h8000));
		queue_random(230);
		drain();

		// Exact hit: slope one, zero offset and target, zero stop error, count zero as one.
		set_config(32'hFCE0_0000, 32'h0320_0000, 31'd0, 16'h0100, 36'd0, 36'd0, 36'd0, 8'd0);
		pending_items.push_back(make_item(KIND_LOAD, 7'd0, 32'h0, 32'h0010_0000, 16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_SWEEP, 7'd0, 32'h0, 32'h0, 16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_MOVE, 7'd0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF));
		queue_random(300);
		drain();

		// Phase two: the sender idles in nearly half the cycles, the receiver in a third.
		send_idle_pct = 46;
		recv_stall_pct = 34;
		// Widest clamps and saturating fitness.
		set_config(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h7FFF, 36'h8_0000_0000,
			36'h7_FFFF_FFFF, 36'hF_FFFF_FFFF, 8'd128);
		pending_items.push_back(make_item(KIND_LOAD, 7'd1, 32'h8000_0000, 32'h0, 16'h0, 16'h0));
		pending_items.push_back(make_item(KIND_SWEEP, 7'd0, 32'h0, 32'h0, 16'h0, 16'h0));
		queue_random(300);
		drain();
		// Inverted clamps and a count above the particle range.
		set_config(32'h0200_0000, 32'hFE00_0000, 31'h0040_0000, 16'h8000, 36'h7_FFFF_FFFF,
			36'h8_0000_0000, 36'd1049, 8'd255);
		queue_random(300);
		drain();

		// Phase three: no idling on either side.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(32'hF000_0000, 32'h1000_0000, 31'h0010_0000, 16'd3328, 36'd17825792,
			36'd127926272, 36'h40_0000, 8'd1);
		queue_random(300);
		drain();
		set_config(32'd1048576, 32'd1048576000, 31'd10486, 16'd3328, 36'd17825792,
			36'd127926272, 36'd1049, 8'd100);
		queue_random(300);
		drain();

		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/pso_pkg.sv
design/pso_mul.sv
design/particle_swarm_optimizer.sv
tb/tb.sv
